// ===== sv/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg: types and codes shared by the first-fit partition allocator
// Input and result payload structs, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package ffpa_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FREED     = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
  localparam logic [2:0] ST_NOT_OWNED = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  pid;
    logic [16:0] req_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  block_index;
    logic [15:0] block_start;
    logic [16:0] free_bytes;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/first_fit_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_partition_allocator: first-fit dynamic partition allocator
// Ordered block table in one synchronous memory; a sequencer scans it,
// shifts entries for a split, frees by pid, compacts free runs and sums.
// ----------------------------------------------------------------------------
// Sequencing: every item makes passes over the live entries, reading one entry
// per cycle: alloc scans, for a split shifts each moved entry (read, then
// write) and writes both parts, then sums; free releases, compacts if any
// entry was freed, then sums. A zero-size alloc only sums.
// Throughput: one item at a time; the next is taken once the result is out.
// Reset: table holds one free block covering the whole memory (entry 0);
// entries beyond the live count are never read, so no clearing pass.
`default_nettype none
module first_fit_partition_allocator #(
  parameter int MAX_BLOCKS = 32,
  parameter int MEM_BYTES  = 65536
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ffpa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ffpa_pkg::out_item_t  out_data
);
  import ffpa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] size;
    logic        free;
    logic [7:0]  owner;
  } entry_t;

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FIND  = 10'b0000000010, // scan for first fit
    S_SHIFT = 10'b0000000100, // move entries up by one for a split
    S_SPLIT = 10'b0000001000, // write allocated part and remainder
    S_REL   = 10'b0000010000, // release entries owned by pid
    S_CMP   = 10'b0000100000, // compact: merge adjacent free runs
    S_CTAIL = 10'b0001000000, // write last compacted entry
    S_SUM   = 10'b0010000000, // sum free sizes
    S_OUT   = 10'b0100000000,
    S_WAIT  = 10'b1000000000  // read latency slot
  } state_t;

  state_t state_r, state_nxt;

  // initial table entry written during reset
  entry_t init_e;
  assign init_e = '{start: '0, size: 17'(MEM_BYTES), free: 1'b1, owner: '0};

  // table memory
  entry_t mem [MAX_BLOCKS];
  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mem[0] <= init_e;
    else if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // working registers
  in_item_t      item_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;      // next address to read
  logic [CW-1:0] wptr_r, wptr_nxt;    // compaction write pointer
  logic          rv_r, rv_nxt;        // rdata_r holds entry ptr_r-1
  logic [IW-1:0] hit_r, hit_nxt;
  entry_t        hold_r, hold_nxt;    // found block / pending merged entry
  logic          hv_r, hv_nxt;
  logic          found_r, found_nxt;
  logic [2:0]    stat_r, stat_nxt;
  logic [16:0]   sum_r, sum_nxt;
  state_t        ret_r, ret_nxt;
  out_item_t     out_r, out_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  logic [CW-1:0] rd_idx;
  assign rd_idx = ptr_r - CW'(1);

  always_comb begin
    state_nxt = state_r; used_nxt = used_r; ptr_nxt = ptr_r; wptr_nxt = wptr_r;
    rv_nxt = 1'b0; hit_nxt = hit_r; hold_nxt = hold_r; hv_nxt = hv_r;
    found_nxt = found_r; stat_nxt = stat_r; sum_nxt = sum_r; ret_nxt = ret_r;
    out_nxt = out_r;
    we = 1'b0; waddr = '0; wdata = rdata_r; raddr = '0;
    case (state_r)
      S_IDLE: begin
        ptr_nxt = '0; hv_nxt = 1'b0; found_nxt = 1'b0; sum_nxt = '0;
        out_nxt.block_index = '0; out_nxt.block_start = '0;
        if (in_valid) begin
          if (in_data.cmd == CMD_ALLOC && in_data.req_size == '0) begin
            stat_nxt = ST_BAD_SIZE; state_nxt = S_SUM;
          end else if (in_data.cmd == CMD_ALLOC) begin
            stat_nxt = ST_NO_SPACE; state_nxt = S_FIND;
          end else begin
            state_nxt = S_REL;
          end
        end
      end
      // read one entry per cycle, test the one read last cycle
      S_FIND: begin
        raddr = ptr_r[IW-1:0];
        if (rv_r && rdata_r.free && rdata_r.size >= item_r.req_size) begin
          hit_nxt = rd_idx[IW-1:0]; hold_nxt = rdata_r;
          stat_nxt = ST_ALLOCATED;
          out_nxt.block_index = 5'(rd_idx);
          out_nxt.block_start = rdata_r.start;
          if (rdata_r.size > item_r.req_size && used_r < CW'(MAX_BLOCKS)) begin
            ptr_nxt = used_r - CW'(1); state_nxt = S_SHIFT;
          end else begin
            we = 1'b1; waddr = rd_idx[IW-1:0];
            wdata = rdata_r; wdata.free = 1'b0; wdata.owner = item_r.pid;
            ptr_nxt = '0; state_nxt = S_SUM;
          end
        end else if (ptr_r == used_r) begin
          if (rv_r || used_r == '0) begin ptr_nxt = '0; state_nxt = S_SUM; end
        end else begin
          ptr_nxt = ptr_r + CW'(1); rv_nxt = 1'b1;
        end
      end
      // copy entry ptr to ptr+1 going downward, read then write
      S_SHIFT: begin
        if (ptr_r == CW'(hit_r)) begin
          state_nxt = S_SPLIT;
        end else begin
          raddr = ptr_r[IW-1:0];
          state_nxt = S_WAIT; ret_nxt = S_SHIFT;
        end
      end
      S_WAIT: begin
        we = 1'b1; waddr = IW'(ptr_r + CW'(1)); wdata = rdata_r;
        ptr_nxt = ptr_r - CW'(1); state_nxt = ret_r;
      end
      S_SPLIT: begin
        if (!hv_r) begin
          we = 1'b1; waddr = hit_r;
          wdata.start = hold_r.start; wdata.size = item_r.req_size;
          wdata.free = 1'b0; wdata.owner = item_r.pid;
          hv_nxt = 1'b1;
        end else begin
          we = 1'b1; waddr = IW'(CW'(hit_r) + CW'(1));
          wdata.start = hold_r.start + item_r.req_size[15:0];
          wdata.size = hold_r.size - item_r.req_size;
          wdata.free = 1'b1; wdata.owner = '0;
          used_nxt = used_r + CW'(1); ptr_nxt = '0; hv_nxt = 1'b0;
          state_nxt = S_SUM;
        end
      end
      // release pass: read ahead, write back released entries
      S_REL: begin
        raddr = ptr_r[IW-1:0];
        if (rv_r && !rdata_r.free && rdata_r.owner == item_r.pid) begin
          we = 1'b1; waddr = rd_idx[IW-1:0];
          wdata.free = 1'b1; wdata.owner = '0; found_nxt = 1'b1;
        end
        if (ptr_r == used_r) begin
          ptr_nxt = '0; wptr_nxt = '0; hv_nxt = 1'b0;
          if (found_nxt) begin stat_nxt = ST_FREED; state_nxt = S_CMP; end
          else begin stat_nxt = ST_NOT_OWNED; state_nxt = S_SUM; end
        end else begin
          ptr_nxt = ptr_r + CW'(1); rv_nxt = 1'b1;
        end
      end
      // compaction: hold one pending entry, merge or emit it
      S_CMP: begin
        raddr = ptr_r[IW-1:0];
        if (rv_r) begin
          if (!hv_r) begin
            hold_nxt = rdata_r; hv_nxt = 1'b1;
          end else if (hold_r.free && rdata_r.free) begin
            hold_nxt.size = hold_r.size + rdata_r.size;
          end else begin
            we = 1'b1; waddr = wptr_r[IW-1:0]; wdata = hold_r;
            wptr_nxt = wptr_r + CW'(1); hold_nxt = rdata_r;
          end
        end
        if (ptr_r == used_r) state_nxt = S_CTAIL;
        else begin ptr_nxt = ptr_r + CW'(1); rv_nxt = 1'b1; end
      end
      S_CTAIL: begin
        we = 1'b1; waddr = wptr_r[IW-1:0]; wdata = hold_r;
        used_nxt = wptr_r + CW'(1); ptr_nxt = '0; hv_nxt = 1'b0;
        state_nxt = S_SUM;
      end
      // sum free sizes over live entries
      S_SUM: begin
        raddr = ptr_r[IW-1:0];
        if (rv_r && rdata_r.free) sum_nxt = sum_r + rdata_r.size;
        if (ptr_r == used_r) begin
          out_nxt.status = stat_r; out_nxt.free_bytes = sum_nxt;
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = ptr_r + CW'(1); rv_nxt = 1'b1;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; used_r <= CW'(1); rv_r <= 1'b0;
      hv_r <= 1'b0; found_r <= 1'b0;
    end else begin
      state_r <= state_nxt; used_r <= used_nxt; rv_r <= rv_nxt;
      hv_r <= hv_nxt; found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) item_r <= in_data;
    ptr_r <= ptr_nxt; wptr_r <= wptr_nxt; hit_r <= hit_nxt; hold_r <= hold_nxt;
    stat_r <= stat_nxt; sum_r <= sum_nxt; ret_r <= ret_nxt; out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_checker: port-level checks for the partition allocator
// Watches handshakes and result codes; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ffpa_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input ffpa_pkg::out_item_t  out_data
);
  import ffpa_pkg::*;

  // one item in flight: no input taken while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready during result");

  // an accepted item keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("input ready after accept");

  // a result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

  // non-allocate results carry zero index and start
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_ALLOCATED |->
      out_data.block_index == '0 && out_data.block_start == '0)
    else $error("index on failed result");

  // free bytes never exceed 65536 and the status is a known code
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_bytes <= 17'd65536 && out_data.status <= ST_NOT_OWNED)
    else $error("result out of range");

endmodule

bind first_fit_partition_allocator ffpa_checker u_ffpa_checker (.*);
`default_nettype wire
